>>> src/lsf_pkg.sv
package lsf_pkg;

   localparam int DEF_MAX_POINTS = 256;
   localparam int XY_W           = 16;
   localparam int WORD_W         = 64;
   localparam int FRAC_W         = 16;
   localparam int DVD_W          = WORD_W + FRAC_W;
   localparam int QUOT_W         = 41;
   localparam int STEP_W         = 7;
   localparam int OUT_W          = 32;

   localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

   typedef enum logic {
      MDU_MUL,
      MDU_DIV
   } mdu_op_type;

   typedef struct packed {
      logic              start;
      mdu_op_type        op;
      logic              scale;
      logic [STEP_W-1:0] steps;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mdu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] prod;
      logic [QUOT_W-1:0] quot;
   } mdu_rsp_type;

   typedef struct packed {
      logic load;
      logic step_xy;
      logic step_sum;
      logic clear;
   } acc_ctl_type;

   typedef struct packed {
      logic start;
      logic take;
   } fit_ctl_type;

   typedef struct packed {
      logic                    done;
      logic                    degenerate;
      logic signed [OUT_W-1:0] start_fit_y;
      logic signed [OUT_W-1:0] end_fit_y;
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
   } fit_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XY,
      ST_SUM,
      ST_FIT
   } top_state_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_NSXX,
      F_SXSX,
      F_NSXY,
      F_SXSY,
      F_SLOPE,
      F_SLSX,
      F_ICPT,
      F_FIT0,
      F_FIT1,
      F_DONE
   } fit_state_type;

endpackage

>>> src/lsf_accum.sv
module lsf_accum import lsf_pkg::*; #(
   parameter int  MAX_POINTS = DEF_MAX_POINTS,
   localparam int CNT_W      = $clog2(MAX_POINTS + 1),
   localparam int SX_W       = XY_W + $clog2(MAX_POINTS),
   localparam int SQ_W       = 2 * XY_W + $clog2(MAX_POINTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  acc_ctl_type            ctl,
   input  logic signed [XY_W-1:0] x_in,
   input  logic signed [XY_W-1:0] y_in,
   output logic signed [SX_W-1:0] sum_x,
   output logic signed [SX_W-1:0] sum_y,
   output logic signed [SQ_W-1:0] sum_xx,
   output logic signed [SQ_W-1:0] sum_xy,
   output logic [CNT_W-1:0]       count,
   output logic signed [XY_W-1:0] first_x,
   output logic signed [XY_W-1:0] last_x,
   output logic                   dropped,
   output logic                   room
);

   logic signed [SX_W-1:0]   sx_ff, sy_ff;
   logic signed [SQ_W-1:0]   sxx_ff, sxy_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [XY_W-1:0]   first_x_ff, x_ff, y_ff;
   logic                     dropped_ff;
   logic signed [2*XY_W-1:0] prod_ff, prod_in;
   logic signed [XY_W-1:0]   mul_a, mul_b;

   assign room  = cnt_ff < CNT_W'(MAX_POINTS);
   assign mul_a = ctl.load ? x_in : x_ff;
   assign mul_b = ctl.load ? x_in : y_ff;
   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         sx_ff      <= '0;
         sy_ff      <= '0;
         sxx_ff     <= '0;
         sxy_ff     <= '0;
         cnt_ff     <= '0;
         first_x_ff <= '0;
         dropped_ff <= 1'b0;
      end else begin
         if (ctl.load) begin
            if (room) begin
               if (cnt_ff == '0) begin
                  first_x_ff <= x_in;
               end
               sx_ff  <= sx_ff + SX_W'(x_in);
               sy_ff  <= sy_ff + SX_W'(y_in);
               cnt_ff <= cnt_ff + CNT_W'(1);
            end else begin
               dropped_ff <= 1'b1;
            end
         end
         if (ctl.step_xy) begin
            sxx_ff <= sxx_ff + SQ_W'(prod_ff);
         end
         if (ctl.step_sum) begin
            sxy_ff <= sxy_ff + SQ_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (ctl.load || ctl.step_xy) begin
         prod_ff <= prod_in;
      end
   end

   assign sum_x   = sx_ff;
   assign sum_y   = sy_ff;
   assign sum_xx  = sxx_ff;
   assign sum_xy  = sxy_ff;
   assign count   = cnt_ff;
   assign first_x = first_x_ff;
   assign last_x  = x_ff;
   assign dropped = dropped_ff;

endmodule

>>> src/lsf_mdu.sv
module lsf_mdu import lsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mdu_cmd_type cmd,
   output mdu_rsp_type rsp
);

   mdu_op_type        op_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [WORD_W-1:0] acc_ff, dvs_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [QUOT_W-1:0] q_ff;
   logic              big_ff, done_ff;

   logic              busy, sub, ge, over, rnd;
   logic [WORD_W:0]   opa, opb;
   logic [WORD_W+1:0] alu;

   assign busy = cnt_ff != '0;

   // one shared add/subtract: shift-add multiply or restoring divide
   always_comb begin
      if (op_ff == MDU_DIV) begin
         opa = {acc_ff, dvd_ff[DVD_W-1]};
         sub = 1'b1;
      end else begin
         opa = {1'b0, acc_ff};
         sub = (cnt_ff == STEP_W'(1));
      end
      opb = {1'b0, dvs_ff};
      alu = sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
      ge  = ~alu[WORD_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy && (cnt_ff == STEP_W'(1));
         if (cmd.start) begin
            cnt_ff <= cmd.steps;
         end else if (busy) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.op;
         acc_ff <= '0;
         q_ff   <= '0;
         big_ff <= 1'b0;
         if (cmd.op == MDU_DIV) begin
            dvs_ff <= cmd.b;
            dvd_ff <= cmd.scale ? {cmd.a, {FRAC_W{1'b0}}} : DVD_W'(cmd.a);
         end else begin
            dvs_ff <= cmd.a;
            dvd_ff <= DVD_W'(cmd.b);
         end
      end else if (busy) begin
         if (op_ff == MDU_DIV) begin
            acc_ff <= ge ? alu[WORD_W-1:0] : opa[WORD_W-1:0];
            dvd_ff <= dvd_ff << 1;
            q_ff   <= {q_ff[QUOT_W-2:0], ge};
            big_ff <= big_ff | q_ff[QUOT_W-1];
         end else begin
            if (dvd_ff[0]) begin
               acc_ff <= alu[WORD_W-1:0];
            end
            dvs_ff <= dvs_ff << 1;
            dvd_ff <= dvd_ff >> 1;
         end
      end
   end

   // quotient rounded half away from zero, capped at the magnitude limit
   assign over = big_ff | q_ff[QUOT_W-1];
   assign rnd  = {acc_ff, 1'b0} >= {1'b0, dvs_ff};

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;
   assign rsp.quot = over ? QUOT_CAP : (q_ff + QUOT_W'(rnd));

endmodule

>>> src/lsf_fit.sv
module lsf_fit import lsf_pkg::*; #(
   parameter int  MAX_POINTS = DEF_MAX_POINTS,
   localparam int CNT_W      = $clog2(MAX_POINTS + 1),
   localparam int SX_W       = XY_W + $clog2(MAX_POINTS),
   localparam int SQ_W       = 2 * XY_W + $clog2(MAX_POINTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fit_ctl_type            ctl,
   input  logic signed [SX_W-1:0] sum_x,
   input  logic signed [SX_W-1:0] sum_y,
   input  logic signed [SQ_W-1:0] sum_xx,
   input  logic signed [SQ_W-1:0] sum_xy,
   input  logic [CNT_W-1:0]       count,
   input  logic signed [XY_W-1:0] first_x,
   input  logic signed [XY_W-1:0] last_x,
   output mdu_cmd_type            cmd,
   input  mdu_rsp_type            rsp,
   output fit_res_type            res
);

   localparam int N_STEPS = CNT_W + 1;

   localparam logic signed [WORD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   fit_state_type state_ff, state_in;
   logic          issued_ff, calc;

   logic [WORD_W-1:0]        t_ff, den_ff, num_ff;
   logic signed [OUT_W-1:0]  slope_ff, fit0_ff, fit1_ff;
   logic signed [QUOT_W:0]   icpt_ff;
   logic                     degen_ff;

   function automatic logic [WORD_W-1:0] mag64(logic [WORD_W-1:0] v);
      return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
   endfunction

   function automatic logic signed [WORD_W-1:0] with_sign(logic neg, logic [QUOT_W-1:0] q);
      logic signed [WORD_W-1:0] w;
      w = WORD_W'(q);
      return neg ? -w : w;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat32(logic signed [WORD_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[OUT_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   // p / 2^16, to nearest, ties away from zero
   function automatic logic signed [WORD_W-1:0] rnd16(logic signed [WORD_W-1:0] p);
      logic signed [WORD_W-1:0] half;
      half = p[WORD_W-1] ? WORD_W'(16'h7FFF) : WORD_W'(16'h8000);
      return (p + half) >>> FRAC_W;
   endfunction

   assign calc = (state_ff != F_IDLE) && (state_ff != F_DONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (ctl.start) state_in = F_NSXX;
         F_NSXX:  if (rsp.done) state_in = F_SXSX;
         F_SXSX:  if (rsp.done) state_in = F_NSXY;
         F_NSXY:  if (rsp.done) state_in = F_SXSY;
         F_SXSY:  if (rsp.done) state_in = (den_ff == '0) ? F_DONE : F_SLOPE;
         F_SLOPE: if (rsp.done) state_in = F_SLSX;
         F_SLSX:  if (rsp.done) state_in = F_ICPT;
         F_ICPT:  if (rsp.done) state_in = F_FIT0;
         F_FIT0:  if (rsp.done) state_in = F_FIT1;
         F_FIT1:  if (rsp.done) state_in = F_DONE;
         F_DONE:  if (ctl.take) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.start = calc && !issued_ff;
      cmd.op    = MDU_MUL;
      unique case (state_ff)
         F_NSXX: begin
            cmd.a     = WORD_W'(sum_xx);
            cmd.b     = WORD_W'(count);
            cmd.steps = STEP_W'(N_STEPS);
         end
         F_SXSX: begin
            cmd.a     = WORD_W'(sum_x);
            cmd.b     = WORD_W'(sum_x);
            cmd.steps = STEP_W'(SX_W);
         end
         F_NSXY: begin
            cmd.a     = WORD_W'(sum_xy);
            cmd.b     = WORD_W'(count);
            cmd.steps = STEP_W'(N_STEPS);
         end
         F_SXSY: begin
            cmd.a     = WORD_W'(sum_x);
            cmd.b     = WORD_W'(sum_y);
            cmd.steps = STEP_W'(SX_W);
         end
         F_SLOPE: begin
            cmd.op    = MDU_DIV;
            cmd.scale = 1'b1;
            cmd.a     = mag64(num_ff);
            cmd.b     = den_ff;
            cmd.steps = STEP_W'(DVD_W);
         end
         F_SLSX: begin
            cmd.a     = WORD_W'(slope_ff);
            cmd.b     = WORD_W'(sum_x);
            cmd.steps = STEP_W'(SX_W);
         end
         F_ICPT: begin
            cmd.op    = MDU_DIV;
            cmd.a     = mag64(t_ff);
            cmd.b     = WORD_W'(count) << FRAC_W;
            cmd.steps = STEP_W'(DVD_W);
         end
         F_FIT0: begin
            cmd.a     = WORD_W'(slope_ff);
            cmd.b     = WORD_W'(first_x);
            cmd.steps = STEP_W'(XY_W);
         end
         F_FIT1: begin
            cmd.a     = WORD_W'(slope_ff);
            cmd.b     = WORD_W'(last_x);
            cmd.steps = STEP_W'(XY_W);
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp.done) begin
            issued_ff <= 1'b0;
         end else if (cmd.start) begin
            issued_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.done) begin
         case (state_ff)
            F_NSXX:  t_ff <= rsp.prod;
            F_SXSX:  den_ff <= t_ff - rsp.prod;
            F_NSXY:  t_ff <= rsp.prod;
            F_SXSY: begin
               num_ff   <= t_ff - rsp.prod;
               degen_ff <= (den_ff == '0);
            end
            F_SLOPE: slope_ff <= sat32(with_sign(num_ff[WORD_W-1], rsp.quot));
            F_SLSX:  t_ff <= (WORD_W'(sum_y) << FRAC_W) - rsp.prod;
            F_ICPT:  icpt_ff <= (QUOT_W+1)'(with_sign(t_ff[WORD_W-1], rsp.quot));
            F_FIT0:  fit0_ff <= sat32(rnd16(rsp.prod) + WORD_W'(icpt_ff));
            F_FIT1:  fit1_ff <= sat32(rnd16(rsp.prod) + WORD_W'(icpt_ff));
            default: ;
         endcase
      end
   end

   assign res.done        = (state_ff == F_DONE);
   assign res.degenerate  = degen_ff;
   assign res.start_fit_y = fit0_ff;
   assign res.end_fit_y   = fit1_ff;
   assign res.slope       = slope_ff;
   assign res.intercept   = sat32(WORD_W'(icpt_ff));

endmodule

>>> src/least_squares_line_fit.sv
// channel | ports                                            | dir | transfer
// req     | req_valid, req_stall, req_x/y_value, last_point  | in  | valid & !stall
// rsp     | rsp_valid, rsp_stall, rsp_start_x ... overflow   | out | valid & !stall
//
// A summed point passes the XY and SUM states (one 16x16 multiplier, x*x
// then x*y); a point past MAX_POINTS skips both. A last point adds the fit,
// run on one bit-serial multiply/divide unit, one bit per cycle.
// Synchronous active-high reset clears sums, count and both sequencers.
// A finished result sits in the output register; new points are accepted
// meanwhile, and the next fit holds its result until rsp_stall lets it go.
module least_squares_line_fit import lsf_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [XY_W-1:0]  req_x_value,
   input  logic signed [XY_W-1:0]  req_y_value,
   input  logic                    req_last_point,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [XY_W-1:0]  rsp_start_x,
   output logic signed [OUT_W-1:0] rsp_start_fit_y,
   output logic signed [XY_W-1:0]  rsp_end_x,
   output logic signed [OUT_W-1:0] rsp_end_fit_y,
   output logic signed [OUT_W-1:0] rsp_slope,
   output logic signed [OUT_W-1:0] rsp_intercept,
   output logic                    rsp_degenerate,
   output logic                    rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SX_W  = XY_W + $clog2(MAX_POINTS);
   localparam int SQ_W  = 2 * XY_W + $clog2(MAX_POINTS);

   top_state_type state_ff, state_in;
   logic          last_ff;
   logic          accept, out_free, unload, stall;

   acc_ctl_type acc_ctl;
   fit_ctl_type fit_ctl;
   fit_res_type fit_res;
   mdu_cmd_type mdu_cmd;
   mdu_rsp_type mdu_rsp;

   logic signed [SX_W-1:0] sum_x, sum_y;
   logic signed [SQ_W-1:0] sum_xx, sum_xy;
   logic [CNT_W-1:0]       count;
   logic signed [XY_W-1:0] first_x, last_x;
   logic                   dropped, room;

   logic                    rsp_valid_ff;
   logic signed [XY_W-1:0]  start_x_ff, end_x_ff;
   logic signed [OUT_W-1:0] start_fit_y_ff, end_fit_y_ff, slope_ff, intercept_ff;
   logic                    degenerate_ff, overflow_ff;

   lsf_accum #(.MAX_POINTS(MAX_POINTS)) u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .x_in    (req_x_value),
      .y_in    (req_y_value),
      .sum_x   (sum_x),
      .sum_y   (sum_y),
      .sum_xx  (sum_xx),
      .sum_xy  (sum_xy),
      .count   (count),
      .first_x (first_x),
      .last_x  (last_x),
      .dropped (dropped),
      .room    (room)
   );

   lsf_fit #(.MAX_POINTS(MAX_POINTS)) u_fit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fit_ctl),
      .sum_x   (sum_x),
      .sum_y   (sum_y),
      .sum_xx  (sum_xx),
      .sum_xy  (sum_xy),
      .count   (count),
      .first_x (first_x),
      .last_x  (last_x),
      .cmd     (mdu_cmd),
      .rsp     (mdu_rsp),
      .res     (fit_res)
   );

   lsf_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (mdu_cmd),
      .rsp   (mdu_rsp)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  state_in = ST_XY;
               end else if (req_last_point) begin
                  state_in = ST_FIT;
               end
            end
         end
         ST_XY:  state_in = ST_SUM;
         ST_SUM: state_in = last_ff ? ST_FIT : ST_IDLE;
         ST_FIT: if (fit_res.done && out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      stall            = (state_ff != ST_IDLE);
      unload           = (state_ff == ST_FIT) && fit_res.done && out_free;
      acc_ctl.load     = req_valid && (state_ff == ST_IDLE);
      acc_ctl.step_xy  = (state_ff == ST_XY);
      acc_ctl.step_sum = (state_ff == ST_SUM);
      acc_ctl.clear    = unload;
      fit_ctl.start    = (state_ff == ST_FIT);
      fit_ctl.take     = unload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (unload) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_last_point;
      end
      if (unload) begin
         degenerate_ff <= fit_res.degenerate;
         overflow_ff   <= dropped;
         if (fit_res.degenerate) begin
            start_x_ff     <= '0;
            end_x_ff       <= '0;
            start_fit_y_ff <= '0;
            end_fit_y_ff   <= '0;
            slope_ff       <= '0;
            intercept_ff   <= '0;
         end else begin
            start_x_ff     <= first_x;
            end_x_ff       <= last_x;
            start_fit_y_ff <= fit_res.start_fit_y;
            end_fit_y_ff   <= fit_res.end_fit_y;
            slope_ff       <= fit_res.slope;
            intercept_ff   <= fit_res.intercept;
         end
      end
   end

   assign req_stall       = stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_x     = start_x_ff;
   assign rsp_start_fit_y = start_fit_y_ff;
   assign rsp_end_x       = end_x_ff;
   assign rsp_end_fit_y   = end_fit_y_ff;
   assign rsp_slope       = slope_ff;
   assign rsp_intercept   = intercept_ff;
   assign rsp_degenerate  = degenerate_ff;
   assign rsp_overflow    = overflow_ff;

endmodule
